// ----- design/bafs_pkg.sv -----
// Shared types and constants for the bracket-aware field splitter.
// No dependencies; imported by bracket_aware_field_splitter_unit.
package bafs_pkg;

    // Configuration register indexes
    typedef logic [2:0] cfg_idx_t;
    localparam cfg_idx_t CFG_SEPARATOR = 3'd0;
    localparam cfg_idx_t CFG_OPEN      = 3'd1;
    localparam cfg_idx_t CFG_CLOSE     = 3'd2;
    localparam cfg_idx_t CFG_PAIRS     = 3'd3;
    localparam cfg_idx_t CFG_OPTIONS   = 3'd4;

    // Configuration reset values
    localparam logic [7:0]  SEPARATOR_RST = 8'd44;
    localparam logic [31:0] OPEN_RST      = 32'd40;
    localparam logic [31:0] CLOSE_RST     = 32'd41;
    localparam logic [2:0]  PAIRS_RST     = 3'd1;
    localparam logic [1:0]  OPTIONS_RST   = 2'd3;

    // Option bits
    localparam int OPT_DROP_EMPTY = 0;
    localparam int OPT_TRIM       = 1;

    // Bracket pair slots packed in the open/close registers
    localparam int PAIR_SLOTS = 4;

    // Result queue geometry
    localparam int OQ_DEPTH = 4;
    localparam int OQ_PW    = 2;
    localparam int OQ_CW    = 3;

    // ASCII whitespace codes
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;

    typedef struct packed {
        logic        has_piece;
        logic [15:0] span_start;
        logic [15:0] span_end;
        logic        string_done;
        logic        unclosed_brackets;
        logic        nesting_overflow;
    } result_t;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
               (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
    endfunction

endpackage

// ----- design/bracket_aware_field_splitter_unit.sv -----
// Bracket-aware field splitter: byte-serial tokenizer with a closer stack in RAM.
// Depends on bafs_pkg (result type, register indexes, whitespace test).
//
//  channel | handshake               | payload
//  --------+-------------------------+---------------------------------------------
//  src     | src_valid / src_stall   | text_byte, end_of_text
//  res     | res_valid / res_stall   | has_piece, span_start, span_end, string_done,
//          |                         | unclosed_brackets, nesting_overflow
//  cfg     | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// One byte is taken per cycle while src_stall is low. A byte yields zero, one or two
// result words; a byte that ends both a piece and the string yields two, and the
// result port then sets the pace at one word per cycle while res_stall is low,
// through a four-entry result queue. The stack top is last cycle's closer RAM read,
// with a push forwarded around the RAM, so back-to-back pushes and pops run at full
// rate. Reset clears all control state; the closer RAM is not cleared and needs no
// pass. src_stall rises when the result queue has fewer than two free entries.
module bracket_aware_field_splitter_unit
    import bafs_pkg::*;
#(
    parameter int STACK_DEPTH = 16,
    parameter int MAX_PAIRS   = 4,
    parameter int OFFSET_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // byte input
    input  logic        src_valid,
    output logic        src_stall,
    input  logic [7:0]  text_byte,
    input  logic        end_of_text,
    // result output
    output logic        res_valid,
    input  logic        res_stall,
    output logic        has_piece,
    output logic [15:0] span_start,
    output logic [15:0] span_end,
    output logic        string_done,
    output logic        unclosed_brackets,
    output logic        nesting_overflow,
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  cfg_idx_t    cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int LW    = $clog2(STACK_DEPTH + 1);
    localparam int AW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int LANES = (MAX_PAIRS < PAIR_SLOTS) ? MAX_PAIRS : PAIR_SLOTS;
    localparam logic [LW-1:0] LEVEL_FULL = LW'(STACK_DEPTH);
    localparam logic [OQ_CW-1:0] OQ_LIMIT = OQ_CW'(OQ_DEPTH - 2);

    // Configuration registers
    logic [7:0]  sep_reg;
    logic [31:0] open_reg;
    logic [31:0] close_reg;
    logic [2:0]  pairs_reg;
    logic [1:0]  opts_reg;

    // Per-string state
    logic [OFFSET_BITS-1:0] offset_reg, offset_next;
    logic [OFFSET_BITS-1:0] begin_reg, begin_next;
    logic [OFFSET_BITS-1:0] last_end_reg, last_end_next;
    logic [OFFSET_BITS-1:0] first_reg, first_next;
    logic                   seen_reg, seen_next;
    logic                   skip_reg, skip_next;
    logic                   inside_reg, inside_next;
    logic                   ovf_reg, ovf_next;
    logic [LW-1:0]          level_reg, level_next;

    // Closer stack RAM and forwarding
    logic [7:0]    closer_mem [STACK_DEPTH];
    logic [7:0]    rd_data_reg;
    logic          fwd_reg;
    logic [7:0]    fwd_data_reg;
    logic [AW-1:0] rd_addr;
    logic [7:0]    stack_top;
    logic          push_en;
    logic [7:0]    push_data;

    // Result queue
    result_t          oq_mem [OQ_DEPTH];
    logic [OQ_PW-1:0] oq_wr_reg, oq_rd_reg;
    logic [OQ_CW-1:0] oq_count_reg;
    logic             emit0, emit1;
    result_t          res0, res1;
    logic             src_accept, res_accept;

    assign cfg_ready  = 1'b1;
    assign src_stall  = (oq_count_reg > OQ_LIMIT);
    assign src_accept = src_valid && !src_stall;
    assign res_valid  = (oq_count_reg != '0);
    assign res_accept = res_valid && !res_stall;
    assign stack_top  = fwd_reg ? fwd_data_reg : rd_data_reg;

    // Configuration write port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sep_reg   <= SEPARATOR_RST;
            open_reg  <= OPEN_RST;
            close_reg <= CLOSE_RST;
            pairs_reg <= PAIRS_RST;
            opts_reg  <= OPTIONS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_SEPARATOR: sep_reg   <= cfg_data[7:0];
                CFG_OPEN:      open_reg  <= cfg_data;
                CFG_CLOSE:     close_reg <= cfg_data;
                CFG_PAIRS:     pairs_reg <= cfg_data[2:0];
                CFG_OPTIONS:   opts_reg  <= cfg_data[1:0];
                default:       ;
            endcase
        end
    end

    // Classify the byte and work out the next string state and results
    always_comb
    begin
        logic [OFFSET_BITS-1:0] nxt;
        logic [OFFSET_BITS-1:0] s_old, e_old, s_fin, e_fin;
        logic       trim, drop, sep_zero, ws;
        logic       sep_hit, close_hit, open_hit, open_found, cut, is_text;
        logic       fin_has;
        logic [7:0] open_closer;

        nxt      = offset_reg + OFFSET_BITS'(1);
        trim     = opts_reg[OPT_TRIM];
        drop     = opts_reg[OPT_DROP_EMPTY];
        sep_zero = (sep_reg == 8'd0);
        ws       = is_ws(text_byte);

        offset_next   = offset_reg;
        begin_next    = begin_reg;
        last_end_next = last_end_reg;
        first_next    = first_reg;
        seen_next     = seen_reg;
        skip_next     = skip_reg;
        inside_next   = inside_reg;
        ovf_next      = ovf_reg;
        level_next    = level_reg;
        push_en       = 1'b0;
        push_data     = 8'd0;
        emit0         = 1'b0;
        emit1         = 1'b0;
        sep_hit       = 1'b0;
        close_hit     = 1'b0;
        open_hit      = 1'b0;
        cut           = 1'b0;
        is_text       = 1'b0;

        // span of the current piece ending at this byte, old state
        s_old = begin_reg;
        e_old = offset_reg;
        if (trim)
        begin
            s_old = seen_reg ? first_reg : begin_reg;
            e_old = seen_reg ? last_end_reg : begin_reg;
        end

        // first matching opener among the pairs in use
        open_found  = 1'b0;
        open_closer = 8'd0;
        for (int i = 0; i < LANES; i++)
        begin
            if (!open_found && (3'(i) < pairs_reg) && (text_byte == open_reg[8*i +: 8]))
            begin
                open_found  = 1'b1;
                open_closer = close_reg[8*i +: 8];
            end
        end

        if (src_accept)
        begin
            if (skip_reg && trim && ws)
            begin
                // swallow leading whitespace
                begin_next = nxt;
            end
            else
            begin
                skip_next = 1'b0;
                sep_hit   = !inside_reg && !sep_zero && (text_byte == sep_reg);
                close_hit = !sep_hit && (level_reg != '0) && (text_byte == stack_top);
                open_hit  = !sep_hit && !close_hit && open_found;

                if (sep_hit)
                begin
                    emit0     = !(drop && (s_old == e_old));
                    cut       = 1'b1;
                    skip_next = 1'b1;
                end
                else if (close_hit)
                begin
                    level_next  = level_reg - LW'(1);
                    cut         = sep_zero && (level_reg == LW'(1));
                    emit0       = cut;
                    inside_next = (level_reg != LW'(1));
                end
                else if (open_hit)
                begin
                    cut = sep_zero && (level_reg == '0);
                    emit0 = cut;
                    if (level_reg < LEVEL_FULL)
                    begin
                        push_en    = 1'b1;
                        push_data  = open_closer;
                        level_next = level_reg + LW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    inside_next = 1'b1;
                end

                if (cut)
                begin
                    begin_next = nxt;
                    seen_next  = 1'b0;
                end

                // track the non-space extent of the piece
                is_text = !cut;
                if (is_text && !ws)
                begin
                    if (!seen_reg)
                    begin
                        first_next = offset_reg;
                        seen_next  = 1'b1;
                    end
                    last_end_next = nxt;
                end
            end
        end

        res0.has_piece         = 1'b1;
        res0.span_start        = 16'(s_old);
        res0.span_end          = 16'(e_old);
        res0.string_done       = 1'b0;
        res0.unclosed_brackets = 1'b0;
        res0.nesting_overflow  = ovf_reg;

        // closing record from the updated state
        s_fin = begin_next;
        e_fin = nxt;
        if (trim)
        begin
            s_fin = seen_next ? first_next : begin_next;
            e_fin = seen_next ? last_end_next : begin_next;
        end
        fin_has = !(drop && (s_fin == e_fin));

        res1.has_piece         = fin_has;
        res1.span_start        = fin_has ? 16'(s_fin) : 16'd0;
        res1.span_end          = fin_has ? 16'(e_fin) : 16'd0;
        res1.string_done       = 1'b1;
        res1.unclosed_brackets = (level_next != '0);
        res1.nesting_overflow  = ovf_next;

        if (src_accept)
        begin
            if (end_of_text)
            begin
                emit1         = 1'b1;
                offset_next   = '0;
                begin_next    = '0;
                last_end_next = '0;
                first_next    = '0;
                seen_next     = 1'b0;
                skip_next     = 1'b1;
                inside_next   = 1'b0;
                ovf_next      = 1'b0;
                level_next    = '0;
            end
            else
            begin
                offset_next = nxt;
            end
        end

        // read the entry that will be on top next cycle
        rd_addr = AW'(level_next - LW'(1));
    end

    // Advance per-string state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg   <= '0;
            begin_reg    <= '0;
            last_end_reg <= '0;
            first_reg    <= '0;
            seen_reg     <= 1'b0;
            skip_reg     <= 1'b1;
            inside_reg   <= 1'b0;
            ovf_reg      <= 1'b0;
            level_reg    <= '0;
            fwd_reg      <= 1'b0;
        end
        else
        begin
            offset_reg   <= offset_next;
            begin_reg    <= begin_next;
            last_end_reg <= last_end_next;
            first_reg    <= first_next;
            seen_reg     <= seen_next;
            skip_reg     <= skip_next;
            inside_reg   <= inside_next;
            ovf_reg      <= ovf_next;
            level_reg    <= level_next;
            fwd_reg      <= push_en;
        end
    end

    // Closer stack RAM: push writes, read-old, pushed value forwarded
    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            closer_mem[level_reg[AW-1:0]] <= push_data;
        end
        rd_data_reg  <= closer_mem[rd_addr];
        fwd_data_reg <= push_data;
    end

    // Result queue storage
    always_ff @(posedge clk)
    begin
        if (emit0)
        begin
            oq_mem[oq_wr_reg] <= res0;
        end
        if (emit1)
        begin
            oq_mem[oq_wr_reg + OQ_PW'(emit0)] <= res1;
        end
    end

    // Result queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_reg    <= '0;
            oq_rd_reg    <= '0;
            oq_count_reg <= '0;
        end
        else
        begin
            oq_wr_reg    <= oq_wr_reg + OQ_PW'(emit0) + OQ_PW'(emit1);
            oq_rd_reg    <= oq_rd_reg + OQ_PW'(res_accept);
            oq_count_reg <= oq_count_reg + OQ_CW'(emit0) + OQ_CW'(emit1)
                            - OQ_CW'(res_accept);
        end
    end

    assign has_piece         = oq_mem[oq_rd_reg].has_piece;
    assign span_start        = oq_mem[oq_rd_reg].span_start;
    assign span_end          = oq_mem[oq_rd_reg].span_end;
    assign string_done       = oq_mem[oq_rd_reg].string_done;
    assign unclosed_brackets = oq_mem[oq_rd_reg].unclosed_brackets;
    assign nesting_overflow  = oq_mem[oq_rd_reg].nesting_overflow;

    // Checks
    a_oq_bound: assert property (@(posedge clk) disable iff (!rst_n)
        oq_count_reg <= OQ_CW'(OQ_DEPTH))
        else $error("result queue count beyond depth");

    a_room_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        src_accept |-> (oq_count_reg <= OQ_LIMIT))
        else $error("byte taken without room for two results");

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= LEVEL_FULL)
        else $error("stack level beyond depth");

    a_inside_level: assert property (@(posedge clk) disable iff (!rst_n)
        inside_reg == (level_reg != '0))
        else $error("bracket flag disagrees with stack level");

    a_string_reset: assert property (@(posedge clk) disable iff (!rst_n)
        (src_accept && end_of_text) |=> (offset_reg == '0) && (level_reg == '0))
        else $error("string state not cleared after final byte");

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for bracket_aware_field_splitter_unit: a shadow splitter predicts
// every result word from the accepted bytes, and each word is checked as it leaves the unit.
// Depends on bafs_pkg and the unit itself; reads no files.
module tb_top;
    import bafs_pkg::*;

    localparam int NEST_DEPTH    = 16;
    localparam int PAIR_MAX      = 4;
    localparam int SETTLE_CYCLES = 12;
    localparam int MAX_PRINTED   = 100;

    typedef logic [7:0] byte_q_t[$];

    logic        clk;
    logic        rst_n;
    logic        src_valid;
    logic        src_stall;
    logic [7:0]  text_byte;
    logic        end_of_text;
    logic        res_valid;
    logic        res_stall;
    logic        has_piece;
    logic [15:0] span_start;
    logic [15:0] span_end;
    logic        string_done;
    logic        unclosed_brackets;
    logic        nesting_overflow;
    logic        cfg_valid;
    logic        cfg_ready;
    cfg_idx_t    cfg_index;
    logic [31:0] cfg_data;

    // Shadow copy of the configuration registers
    logic [7:0]  sep_cfg;
    logic [31:0] open_cfg;
    logic [31:0] close_cfg;
    logic [2:0]  pairs_cfg;
    logic [1:0]  opts_cfg;

    // Shadow copy of the per-string splitter state
    logic [15:0] cur_off;
    logic [15:0] piece_start;
    logic [15:0] first_text;
    logic [15:0] text_end;
    logic [7:0]  closers [NEST_DEPTH];
    int          depth;
    bit          in_group;
    bit          lead_ws;
    bit          ovf_flag;
    bit          saw_text;

    result_t     pending_spans[$];
    int          mismatch_count;
    bit          idle_on;
    int          stall_left;

    bracket_aware_field_splitter_unit uut (
        .clk               (clk),
        .rst_n             (rst_n),
        .src_valid         (src_valid),
        .src_stall         (src_stall),
        .text_byte         (text_byte),
        .end_of_text       (end_of_text),
        .res_valid         (res_valid),
        .res_stall         (res_stall),
        .has_piece         (has_piece),
        .span_start        (span_start),
        .span_end          (span_end),
        .string_done       (string_done),
        .unclosed_brackets (unclosed_brackets),
        .nesting_overflow  (nesting_overflow),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // Shadow splitter
    // ------------------------------------------------------------------
    function automatic bit ascii_space(input logic [7:0] c);
        case (c)
            CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic void clear_string_state();
        cur_off     = '0;
        piece_start = '0;
        first_text  = '0;
        text_end    = '0;
        depth       = 0;
        in_group    = 1'b0;
        lead_ws     = 1'b1;
        ovf_flag    = 1'b0;
        saw_text    = 1'b0;
    endfunction

    // Bounds of the piece that ends at stop, trimmed when the option is on
    function automatic void piece_bounds(input logic [15:0] stop,
                                         output logic [15:0] s, output logic [15:0] e);
        if (!opts_cfg[OPT_TRIM]) begin
            s = piece_start;
            e = stop;
        end
        else if (saw_text) begin
            s = first_text;
            e = text_end;
        end
        else begin
            s = piece_start;
            e = piece_start;
        end
    endfunction

    function automatic void expect_word(input bit has, input logic [15:0] s,
                                        input logic [15:0] e, input bit done, input bit unc);
        result_t r;
        r.has_piece         = has;
        r.span_start        = has ? s : 16'd0;
        r.span_end          = has ? e : 16'd0;
        r.string_done       = done;
        r.unclosed_brackets = unc;
        r.nesting_overflow  = ovf_flag;
        pending_spans.insert(pending_spans.size(), r);
    endfunction

    // Advance the shadow splitter by one accepted byte and queue its result words
    function automatic void split_byte(input logic [7:0] c, input bit eot);
        logic [15:0] off;
        logic [15:0] nxt;
        logic [15:0] s;
        logic [15:0] e;
        bit          drop;
        bit          trim;
        bit          plain;
        bit          found;
        int          npairs;
        int          i;
        off   = cur_off;
        nxt   = cur_off + 16'd1;
        drop  = opts_cfg[OPT_DROP_EMPTY];
        trim  = opts_cfg[OPT_TRIM];
        found = 1'b0;
        if (lead_ws && trim && ascii_space(c)) begin
            // swallow leading whitespace of a piece
            piece_start = nxt;
        end
        else begin
            plain   = 1'b1;
            lead_ws = 1'b0;
            if (!in_group && sep_cfg != 8'd0 && c == sep_cfg) begin
                piece_bounds(off, s, e);
                if (!(drop && s == e))
                    expect_word(1'b1, s, e, 1'b0, 1'b0);
                piece_start = nxt;
                saw_text    = 1'b0;
                lead_ws     = 1'b1;
                plain       = 1'b0;
            end
            else if (depth > 0 && c == closers[depth-1]) begin
                depth = depth - 1;
                if (sep_cfg == 8'd0 && depth == 0) begin
                    piece_bounds(off, s, e);
                    expect_word(1'b1, s, e, 1'b0, 1'b0);
                    piece_start = nxt;
                    saw_text    = 1'b0;
                    plain       = 1'b0;
                end
                in_group = depth > 0;
            end
            else begin
                npairs = (pairs_cfg > PAIR_MAX) ? PAIR_MAX : int'(pairs_cfg);
                for (i = 0; i < npairs; i++) begin
                    if (!found && c == open_cfg[8*i +: 8]) begin
                        found = 1'b1;
                        if (sep_cfg == 8'd0 && depth == 0) begin
                            piece_bounds(off, s, e);
                            expect_word(1'b1, s, e, 1'b0, 1'b0);
                            piece_start = nxt;
                            saw_text    = 1'b0;
                            plain       = 1'b0;
                        end
                        // a full stack still counts as an opener, but pushes nothing
                        if (depth < NEST_DEPTH) begin
                            closers[depth] = close_cfg[8*i +: 8];
                            depth = depth + 1;
                        end
                        else
                            ovf_flag = 1'b1;
                        in_group = 1'b1;
                    end
                end
            end
            if (plain && !ascii_space(c)) begin
                if (!saw_text) begin
                    first_text = off;
                    saw_text   = 1'b1;
                end
                text_end = nxt;
            end
        end
        if (eot) begin
            piece_bounds(nxt, s, e);
            expect_word(!(drop && s == e), s, e, 1'b1, depth > 0);
            clear_string_state();
        end
        else
            cur_off = nxt;
    endfunction

    // ------------------------------------------------------------------
    // Result side: random stall bursts and the word checker
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            res_stall  <= 1'b1;
        end
        else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 3);
            res_stall  <= 1'b1;
        end
        else
            res_stall <= 1'b0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatch_count < MAX_PRINTED)
            $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge clk) begin : check_words
        result_t want;
        if (rst_n && res_valid && !res_stall) begin
            if (pending_spans.size() == 0)
                report_mismatch("result word with nothing pending", 0, 0);
            else begin
                want = pending_spans.pop_front();
                if (has_piece !== want.has_piece)
                    report_mismatch("has_piece", has_piece, want.has_piece);
                if (span_start !== want.span_start)
                    report_mismatch("span_start", span_start, want.span_start);
                if (span_end !== want.span_end)
                    report_mismatch("span_end", span_end, want.span_end);
                if (string_done !== want.string_done)
                    report_mismatch("string_done", string_done, want.string_done);
                if (unclosed_brackets !== want.unclosed_brackets)
                    report_mismatch("unclosed_brackets", unclosed_brackets,
                                    want.unclosed_brackets);
                if (nesting_overflow !== want.nesting_overflow)
                    report_mismatch("nesting_overflow", nesting_overflow,
                                    want.nesting_overflow);
            end
        end
    end

    // ------------------------------------------------------------------
    // Byte and configuration drivers
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] c, input bit eot);
        int gap;
        // drop valid for a short burst now and then
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 4);
            src_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        src_valid   <= 1'b1;
        text_byte   <= c;
        end_of_text <= eot;
        @(posedge clk);
        while (src_stall) @(posedge clk);
        split_byte(c, eot);
    endtask

    task automatic send_string(input byte_q_t s);
        foreach (s[k])
            send_byte(s[k], k == s.size() - 1);
    endtask

    // Hold off until every pending word is out and the pipeline has settled
    task automatic drain_results();
        src_valid <= 1'b0;
        while (pending_spans.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic load_config(input logic [7:0] sep, input logic [31:0] opens,
                               input logic [31:0] closes, input logic [2:0] pairs,
                               input logic [1:0] opts);
        drain_results();
        write_reg(CFG_SEPARATOR, {24'd0, sep});
        write_reg(CFG_OPEN, opens);
        write_reg(CFG_CLOSE, closes);
        write_reg(CFG_PAIRS, {29'd0, pairs});
        write_reg(CFG_OPTIONS, {30'd0, opts});
        cfg_valid <= 1'b0;
        sep_cfg   = sep;
        open_cfg  = opens;
        close_cfg = closes;
        pairs_cfg = pairs;
        opts_cfg  = opts;
    endtask

    // ------------------------------------------------------------------
    // String builders
    // ------------------------------------------------------------------
    function automatic logic [7:0] any_space();
        case ($urandom_range(0, 5))
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return CH_LF;
            3: return CH_VT;
            4: return CH_FF;
            default: return CH_CR;
        endcase
    endfunction

    function automatic logic [7:0] any_letter();
        if ($urandom_range(0, 3) == 0)
            return 8'h30 + 8'($urandom_range(0, 9));
        return 8'h61 + 8'($urandom_range(0, 25));
    endfunction

    // shape 0: well-formed nesting; shape 1: deep nesting; shape 2: raw noise
    // The open-group stack keeps its top at index 0.
    task automatic build_string(input int shape, output byte_q_t s);
        logic [7:0] open_stack[$];
        int len;
        int limit;
        int npairs;
        int pick;
        int p;
        s      = {};
        npairs = (pairs_cfg > PAIR_MAX) ? PAIR_MAX : int'(pairs_cfg);
        case (shape)
            0: begin len = $urandom_range(1, 20); limit = 3; end
            1: begin len = $urandom_range(20, 45); limit = 20; end
            default: begin len = $urandom_range(1, 16); limit = 0; end
        endcase
        for (int k = 0; k < len; k++) begin
            pick = $urandom_range(0, 99);
            if (shape == 2)
                s.insert(s.size(), 8'($urandom_range(0, 255)));
            else if (npairs > 0 && open_stack.size() < limit && pick < (shape == 1 ? 65 : 15))
            begin
                p = $urandom_range(0, npairs - 1);
                s.insert(s.size(), open_cfg[8*p +: 8]);
                open_stack.push_front(close_cfg[8*p +: 8]);
            end
            else if (open_stack.size() > 0 && pick < (shape == 1 ? 75 : 30))
                s.insert(s.size(), open_stack.pop_front());
            else if (pick < 50)
                s.insert(s.size(), sep_cfg);
            else if (pick < 65)
                s.insert(s.size(), any_space());
            else if (pick < 95)
                s.insert(s.size(), any_letter());
            else
                s.insert(s.size(), 8'($urandom_range(0, 255)));
        end
        // close most groups so the string reaches its trailing pieces
        if (shape != 2 && $urandom_range(0, 4) != 0)
            while (open_stack.size() > 0) s.insert(s.size(), open_stack.pop_front());
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Reset configuration: leading space, protected separator, empty pieces,
    // high bytes, a lone zero byte, stray closer, unclosed and overflowing nesting
    task automatic test_directed_spans();
        byte_q_t s;
        s = {CH_TAB, CH_SPACE, "a", ",", "(", "b", ",", "c", ")", ",", ",", 8'hFF};
        send_string(s);
        s = {8'h00};
        send_string(s);
        s = {",", "x", ")", "(", 8'h80};
        send_string(s);
        s = {};
        repeat (NEST_DEPTH + 1) s.insert(s.size(), "(");
        send_string(s);
    endtask

    // One long string sent back to back with no idling
    task automatic test_long_string();
        int total;
        logic [7:0] c;
        total = 200;
        for (int i = 0; i < total; i++) begin
            if (i % 37 == 36)
                c = sep_cfg;
            else if (i % 7 == 3)
                c = CH_SPACE;
            else
                c = 8'h61 + 8'(i % 26);
            send_byte(c, i == total - 1);
        end
    endtask

    task automatic test_random_strings(input int byte_budget);
        byte_q_t s;
        int sent;
        int roll;
        sent = 0;
        while (sent < byte_budget) begin
            roll = $urandom_range(0, 99);
            build_string(roll < 65 ? 0 : (roll < 80 ? 1 : 2), s);
            send_string(s);
            sent += s.size();
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        rst_n       <= 1'b0;
        src_valid   <= 1'b0;
        text_byte   <= 8'd0;
        end_of_text <= 1'b0;
        cfg_valid   <= 1'b0;
        cfg_index   <= CFG_SEPARATOR;
        cfg_data    <= 32'd0;
        mismatch_count = 0;
        idle_on        = 1'b1;
        sep_cfg   = SEPARATOR_RST;
        open_cfg  = OPEN_RST;
        close_cfg = CLOSE_RST;
        pairs_cfg = PAIRS_RST;
        opts_cfg  = OPTIONS_RST;
        clear_string_state();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_spans();
        test_random_strings(180);

        idle_on = 1'b0;
        test_long_string();
        idle_on = 1'b1;

        // four pairs, no options
        load_config(",", 32'h3C7B5B28, 32'h3E7D5D29, 3'd4, 2'd0);
        test_random_strings(180);
        // bracket extraction, both options
        load_config(8'h00, 32'h3C7B5B28, 32'h3E7D5D29, 3'd4, 2'd3);
        test_random_strings(180);
        // extraction with a quote pair that opens and closes on the same byte
        load_config(8'h00, 32'h00002822, 32'h00002922, 3'd2, 2'd1);
        test_random_strings(180);
        // duplicate openers: first pair wins
        load_config(";", 32'h28282222, 32'h29292722, 3'd4, 2'd2);
        test_random_strings(180);
        // whitespace as separator, zero byte as a bracket
        load_config(CH_SPACE, 32'h00005B28, 32'h00005D29, 3'd3, 2'd3);
        test_random_strings(180);
        // top extremes
        load_config(8'hFF, 32'hFFFFFFFF, 32'h00000000, 3'd4, 2'd1);
        test_random_strings(180);
        // bottom extremes, no idling from here on
        idle_on = 1'b0;
        load_config(8'h00, 32'h00000000, 32'hFFFFFFFF, 3'd0, 2'd2);
        test_random_strings(180);

        drain_results();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && pending_spans.size() == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

    // Watchdog
    initial begin
        #100_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

endmodule
